### hdl/tbs_pkg.sv
package tbs_pkg;

	localparam int QUEUE_DEPTH_DEF = 64;

	localparam int RATE_W  = 20;
	localparam int DEPTH_W = 24;
	localparam int LIMIT_W = 7;
	localparam int BYTES_W = 14;
	localparam int TAG_W   = 16;
	localparam int ENTRY_W = TAG_W + BYTES_W;
	localparam int BITS_W  = BYTES_W + 3;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic [1:0] REG_RATE  = 2'd0;
	localparam logic [1:0] REG_DEPTH = 2'd1;
	localparam logic [1:0] REG_LIMIT = 2'd2;

	localparam logic [1:0] VERDICT_FWD  = 2'd0;
	localparam logic [1:0] VERDICT_QUE  = 2'd1;
	localparam logic [1:0] VERDICT_DROP = 2'd2;
	localparam logic [1:0] VERDICT_REL  = 2'd3;

	localparam logic REQ_PKT  = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} tbs_state_t;

endpackage

### hdl/tbs_ram.sv
module tbs_ram #(
	parameter int WIDTH = 30,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hdl/token_bucket_shaper_unit.sv
// channel  | handshake           | payload
// ---------+---------------------+-------------------------------
// input    | in_valid / in_stall | req_type, pkt_bytes, pkt_tag
// output   | out_valid/out_stall | verdict, out_tag, out_bytes
// config   | APB write/read      | rate, depth, limit registers
//
// Per transaction, accept registers the item and reads the queue head from the wait RAM;
// a following update step then updates tokens, pointers and the RAM.
// The update cycle holds while a previous result sits unaccepted in the output register.
// Reset clears tokens, pointers, counts and registers; the wait RAM is not cleared.
module token_bucket_shaper_unit #(
	parameter int QUEUE_DEPTH = tbs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          req_type,
	input  logic [tbs_pkg::BYTES_W-1:0]   pkt_bytes,
	input  logic [tbs_pkg::TAG_W-1:0]     pkt_tag,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    verdict,
	output logic [tbs_pkg::TAG_W-1:0]     out_tag,
	output logic [tbs_pkg::BYTES_W-1:0]   out_bytes,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tbs_pkg::PADDR_W-1:0]   paddr,
	input  logic [tbs_pkg::PDATA_W-1:0]   pwdata,
	output logic [tbs_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);
	import tbs_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int LIM_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [LIM_W-1:0] LIM_MAX  = LIM_W'(QUEUE_DEPTH);

	logic [RATE_W-1:0]  rate_q;
	logic [DEPTH_W-1:0] depth_q;
	logic [LIMIT_W-1:0] limit_q;

	tbs_state_t state_q;

	logic               req_q;
	logic [BYTES_W-1:0] bytes_q;
	logic [TAG_W-1:0]   tag_q;

	logic [DEPTH_W-1:0] tokens_q;
	logic               started_q;
	logic [PTR_W-1:0]   head_q;
	logic [PTR_W-1:0]   tail_q;
	logic [CNT_W-1:0]   count_q;

	logic               out_valid_q;
	logic [1:0]         verdict_q;
	logic [TAG_W-1:0]   out_tag_q;
	logic [BYTES_W-1:0] out_bytes_q;

	logic [ENTRY_W-1:0] ram_rdata;
	logic               wr_cfg;
	logic               accept;
	logic               go;

	logic [DEPTH_W-1:0] tok0;
	logic [DEPTH_W:0]   tok_sum;
	logic [DEPTH_W-1:0] tok_tick;
	logic [DEPTH_W-1:0] tok_clamp;
	logic [DEPTH_W-1:0] head_bits;
	logic [DEPTH_W-1:0] pkt_bits;
	logic [LIM_W-1:0]   limit_eff;
	logic [LIM_W-1:0]   count_ext;

	logic [DEPTH_W-1:0] tokens_n;
	logic               push;
	logic               pop;
	logic               res_v;
	logic [1:0]         res_verdict;
	logic [TAG_W-1:0]   res_tag;
	logic [BYTES_W-1:0] res_bytes;

	assign pready = 1'b1;
	assign wr_cfg = psel & penable & pwrite;

	always_comb begin
		case (paddr[3:2])
			REG_RATE:  prdata = PDATA_W'(rate_q);
			REG_DEPTH: prdata = PDATA_W'(depth_q);
			REG_LIMIT: prdata = PDATA_W'(limit_q);
			default:   prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q  <= '0;
			depth_q <= '0;
			limit_q <= '0;
		end else if (wr_cfg) begin
			case (paddr[3:2])
				REG_RATE:  rate_q  <= pwdata[RATE_W-1:0];
				REG_DEPTH: depth_q <= pwdata[DEPTH_W-1:0];
				REG_LIMIT: limit_q <= pwdata[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid & ~in_stall;
	assign go       = (state_q == ST_EXEC) & (~out_valid_q | ~out_stall);

	tbs_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH),
		.AW   (PTR_W)
	) u_wait_ram (
		.clk  (clk),
		.we   (go & push),
		.waddr(tail_q),
		.wdata({tag_q, bytes_q}),
		.raddr(head_q),
		.rdata(ram_rdata)
	);

	assign limit_eff = (LIM_W'(limit_q) > LIM_MAX) ? LIM_MAX : LIM_W'(limit_q);
	assign count_ext = LIM_W'(count_q);

	assign tok0      = started_q ? tokens_q : depth_q;
	assign tok_sum   = {1'b0, tok0} + (DEPTH_W + 1)'(rate_q);
	assign tok_tick  = (tok_sum > {1'b0, depth_q}) ? depth_q : tok_sum[DEPTH_W-1:0];
	assign tok_clamp = (tok0 > depth_q) ? depth_q : tok0;
	assign head_bits = DEPTH_W'({ram_rdata[BYTES_W-1:0], 3'b000});
	assign pkt_bits  = DEPTH_W'({bytes_q, 3'b000});

	always_comb begin
		tokens_n    = tok0;
		push        = 1'b0;
		pop         = 1'b0;
		res_v       = 1'b0;
		res_verdict = VERDICT_DROP;
		res_tag     = tag_q;
		res_bytes   = bytes_q;
		if (req_q == REQ_TICK) begin
			tokens_n  = tok_tick;
			res_tag   = ram_rdata[ENTRY_W-1:BYTES_W];
			res_bytes = ram_rdata[BYTES_W-1:0];
			if (count_q != '0 && tok_tick >= head_bits) begin
				tokens_n    = tok_tick - head_bits;
				pop         = 1'b1;
				res_v       = 1'b1;
				res_verdict = VERDICT_REL;
			end
		end else if (count_q != '0) begin
			res_v = 1'b1;
			if (count_ext < limit_eff) begin
				push        = 1'b1;
				res_verdict = VERDICT_QUE;
			end
		end else begin
			res_v    = 1'b1;
			tokens_n = tok_clamp;
			if (tok_clamp >= pkt_bits) begin
				tokens_n    = tok_clamp - pkt_bits;
				res_verdict = VERDICT_FWD;
			end else if (limit_eff != '0) begin
				push        = 1'b1;
				res_verdict = VERDICT_QUE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q   <= req_type;
			bytes_q <= pkt_bytes;
			tag_q   <= pkt_tag;
		end
		if (go && res_v) begin
			verdict_q   <= res_verdict;
			out_tag_q   <= res_tag;
			out_bytes_q <= res_bytes;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tokens_q    <= '0;
			started_q   <= 1'b0;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (go) begin
				tokens_q  <= tokens_n;
				started_q <= 1'b1;
				if (push) begin
					tail_q  <= (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;
					count_q <= count_q + 1'b1;
				end
				if (pop) begin
					head_q  <= (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
					count_q <= count_q - 1'b1;
				end
			end

			if (go && res_v) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign verdict   = verdict_q;
	assign out_tag   = out_tag_q;
	assign out_bytes = out_bytes_q;

endmodule

### bench/tb_token_bucket_shaper_unit.sv
`timescale 1ns / 1ps

module tb_token_bucket_shaper_unit;
	import tbs_pkg::*;

	localparam int QDEPTH      = QUEUE_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 500000;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic               kind;
		logic [BYTES_W-1:0] bytes;
		logic [TAG_W-1:0]   tag;
	} shaper_req_t;

	typedef struct packed {
		logic [1:0]         verdict;
		logic [TAG_W-1:0]   tag;
		logic [BYTES_W-1:0] bytes;
	} shaper_out_t;

	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               req_type = REQ_PKT;
	logic [BYTES_W-1:0] pkt_bytes = '0;
	logic [TAG_W-1:0]   pkt_tag  = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         verdict;
	logic [TAG_W-1:0]   out_tag;
	logic [BYTES_W-1:0] out_bytes;
	logic               psel    = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite  = 1'b0;
	logic [PADDR_W-1:0] paddr   = '0;
	logic [PDATA_W-1:0] pwdata  = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	// shaper mirror
	int unsigned cfg_rate;
	int unsigned cfg_depth;
	int unsigned cfg_limit;
	int unsigned tokens;
	bit          bucket_primed;
	shaper_req_t backlog_q[$];
	shaper_out_t verdict_q[$];

	shaper_req_t req_q[$];
	shaper_req_t cur_req;
	int          n_pushed;
	int          n_accepted;
	int          n_checked;
	int          n_errors;
	int          n_verdict[4];
	int          n_cycles;
	int          send_gap;
	int          stall_left;
	int          hold_left;
	int          holds_asked;
	int          holds_served;
	int          in_idle_pct;
	int          out_idle_pct;

	token_bucket_shaper_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.pkt_bytes (pkt_bytes),
		.pkt_tag   (pkt_tag),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.verdict   (verdict),
		.out_tag   (out_tag),
		.out_bytes (out_bytes),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void shape_item(input shaper_req_t r);
		int unsigned lim;
		int unsigned sum;
		int unsigned need;
		shaper_req_t head;
		lim = (cfg_limit > QDEPTH) ? QDEPTH : cfg_limit;
		if (!bucket_primed) begin
			tokens = cfg_depth;
			bucket_primed = 1'b1;
		end
		if (r.kind == REQ_TICK) begin
			sum = tokens + cfg_rate;
			tokens = (sum > cfg_depth) ? cfg_depth : sum;
			if (backlog_q.size() == 0)
				return;
			head = backlog_q[0];
			need = 32'(head.bytes) << 3;
			if (tokens < need)
				return;
			tokens -= need;
			void'(backlog_q.pop_front());
			verdict_q.push_back('{VERDICT_REL, head.tag, head.bytes});
			return;
		end
		need = 32'(r.bytes) << 3;
		if (backlog_q.size() != 0) begin
			if (backlog_q.size() < lim) begin
				backlog_q.push_back(r);
				verdict_q.push_back('{VERDICT_QUE, r.tag, r.bytes});
			end else begin
				verdict_q.push_back('{VERDICT_DROP, r.tag, r.bytes});
			end
			return;
		end
		if (tokens > cfg_depth)
			tokens = cfg_depth;
		if (tokens >= need) begin
			tokens -= need;
			verdict_q.push_back('{VERDICT_FWD, r.tag, r.bytes});
		end else if (lim != 0) begin
			backlog_q.push_back(r);
			verdict_q.push_back('{VERDICT_QUE, r.tag, r.bytes});
		end else begin
			verdict_q.push_back('{VERDICT_DROP, r.tag, r.bytes});
		end
	endfunction

	// mostly short gaps, one in eight long
	function automatic int pick_gap(input int pct);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll >= pct)
			return 0;
		if (roll < pct / 8)
			return $urandom_range(12, 40);
		return $urandom_range(1, 3);
	endfunction

	function automatic void add_req(input logic kind, input logic [BYTES_W-1:0] bytes,
			input logic [TAG_W-1:0] tag);
		req_q.push_back('{kind, bytes, tag});
		n_pushed++;
	endfunction

	function automatic void add_random(input int tick_pct, input int max_bytes);
		int roll;
		logic [BYTES_W-1:0] b;
		roll = $urandom_range(0, 99);
		if (roll < 5)
			b = '1;
		else if (roll < 10)
			b = BYTES_W'($urandom);
		else
			b = BYTES_W'($urandom_range(0, max_bytes));
		add_req(($urandom_range(0, 99) < tick_pct) ? REQ_TICK : REQ_PKT, b, TAG_W'($urandom));
	endfunction

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_RATE:  cfg_rate  = 32'(val[RATE_W-1:0]);
			REG_DEPTH: cfg_depth = 32'(val[DEPTH_W-1:0]);
			REG_LIMIT: cfg_limit = 32'(val[LIMIT_W-1:0]);
			default: ;
		endcase
	endtask

	task automatic set_shaper(input int unsigned rate, input int unsigned depth,
			input int unsigned limit);
		write_reg(REG_RATE, rate);
		write_reg(REG_DEPTH, depth);
		write_reg(REG_LIMIT, limit);
	endtask

	// let every transaction and result settle, then allow the final update to finish
	task automatic drain();
		do @(negedge clk); while (n_accepted != n_pushed || verdict_q.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				shape_item(cur_req);
				n_accepted++;
			end
			if (!in_valid || !in_stall) begin
				if (send_gap != 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (req_q.size() != 0) begin
					cur_req = req_q.pop_front();
					in_valid  <= 1'b1;
					req_type  <= cur_req.kind;
					pkt_bytes <= cur_req.bytes;
					pkt_tag   <= cur_req.tag;
					send_gap = pick_gap(in_idle_pct);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result backpressure
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (holds_served != holds_asked) begin
			holds_served++;
			hold_left = HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			stall_left = pick_gap(out_idle_pct);
			out_stall <= (stall_left != 0);
			if (stall_left != 0)
				stall_left--;
		end
	end

	// result monitor
	always @(posedge clk) begin
		shaper_out_t exp_out;
		if (arst_n && out_valid && !out_stall) begin
			if (verdict_q.size() == 0) begin
				if (n_errors < 10)
					$display("unexpected result: verdict %0d tag %h bytes %0d",
						verdict, out_tag, out_bytes);
				n_errors++;
			end else begin
				exp_out = verdict_q.pop_front();
				n_checked++;
				n_verdict[exp_out.verdict]++;
				if (verdict !== exp_out.verdict || out_tag !== exp_out.tag ||
						out_bytes !== exp_out.bytes) begin
					if (n_errors < 10)
						$display("result %0d mismatch: exp %0d/%h/%0d got %0d/%h/%0d",
							n_checked, exp_out.verdict, exp_out.tag, exp_out.bytes,
							verdict, out_tag, out_bytes);
					n_errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles == CYCLE_LIMIT) begin
			$display("token_bucket_shaper_unit regression: fail");
			$finish;
		end
	end

	initial begin
		int unsigned depth;
		int mb;
		in_idle_pct  = 20;
		out_idle_pct = 20;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// first item a tick: bucket fills before the tick applies
		set_shaper(800, 16000, 2);
		add_req(REQ_TICK, '0, '0);
		add_req(REQ_PKT, 1000, 16'h0000);
		add_req(REQ_PKT, 16383, 16'h1234);
		add_req(REQ_PKT, 0, 16'hFFFF);
		add_req(REQ_PKT, 5, 16'h0005);
		add_req(REQ_TICK, '1, '1);
		drain();
		write_reg(REG_DEPTH, 32'hFFFFFF);
		write_reg(REG_RATE, 32'hFFFFF);
		add_req(REQ_TICK, '0, '0);
		add_req(REQ_TICK, '0, '0);
		add_req(REQ_PKT, 0, 16'h00AA);
		drain();
		// depth lowered under held tokens, zero rate, then limit under the backlog
		set_shaper(0, 800, 4);
		add_req(REQ_PKT, 50, 16'h0050);
		add_req(REQ_PKT, 100, 16'h0100);
		add_req(REQ_PKT, 1, 16'h0001);
		add_req(REQ_PKT, 2, 16'h0002);
		add_req(REQ_TICK, '0, '0);
		drain();
		write_reg(REG_LIMIT, 1);
		add_req(REQ_PKT, 300, 16'h0300);
		drain();
		write_reg(REG_RATE, 400);
		repeat (3) add_req(REQ_TICK, '0, '0);
		drain();
		set_shaper(0, 0, 0);
		add_req(REQ_PKT, 0, 16'hA5A5);
		add_req(REQ_PKT, 1, 16'h5A5A);
		add_req(REQ_TICK, '0, '0);
		drain();

		in_idle_pct  = 30;
		out_idle_pct = 30;
		set_shaper(4000, 40000, 8);
		repeat (200) add_random(50, 1500);
		drain();

		// full-scale bucket, no input idling, one long output hold
		in_idle_pct  = 0;
		out_idle_pct = 20;
		set_shaper(32'hFFFFF, 32'hFFFFFF, 64);
		holds_asked++;
		repeat (200) add_random(30, 16383);
		drain();

		in_idle_pct  = 20;
		out_idle_pct = 0;
		set_shaper(2000, 20000, 0);
		repeat (200) add_random(50, 1000);
		drain();

		// limit past the store size: backlog fills to the store depth, then drains
		set_shaper(0, 1000, 100);
		repeat (80) add_req(REQ_PKT, BYTES_W'($urandom_range(126, 1000)), TAG_W'($urandom));
		drain();
		write_reg(REG_RATE, 60000);
		write_reg(REG_DEPTH, 200000);
		repeat (150) add_random(60, 3000);
		drain();

		in_idle_pct  = 40;
		out_idle_pct = 40;
		set_shaper(500, 8000, 127);
		repeat (200) add_random(60, 500);
		drain();

		repeat (4) begin
			in_idle_pct  = $urandom_range(0, 50);
			out_idle_pct = $urandom_range(0, 50);
			depth = $urandom_range(0, 32'hFFFFFF);
			mb = ((depth >> 3) > 16383) ? 16383 : int'(depth >> 3);
			set_shaper($urandom_range(0, 32'hFFFFF), depth, $urandom_range(0, 127));
			repeat (75) add_random(50, mb);
			drain();
		end

		repeat (10) @(posedge clk);
		n_errors += verdict_q.size();
		$display("shaper: %0d transactions in, %0d results:", n_accepted, n_checked);
		$display("  %0d fwd, %0d queued, %0d dropped, %0d released",
			n_verdict[VERDICT_FWD], n_verdict[VERDICT_QUE],
			n_verdict[VERDICT_DROP], n_verdict[VERDICT_REL]);
		$display("swept rate, depth and limit to both extremes, policer mode and a long output hold");
		if (n_errors == 0)
			$display("token_bucket_shaper_unit regression: pass");
		else
			$display("token_bucket_shaper_unit regression: fail");
		$finish;
	end

endmodule
